// ===== rtl/pova_pkg.sv =====
package pova_pkg;

    // internal angle width, 2^-16 degree
    localparam int ZW = 26;
    // rotation cordic datapath width
    localparam int RW = 34;
    // scaled tangent width
    localparam int NW = 36;
    // vectoring cordic datapath width
    localparam int VW = 56;
    // fractional bits of internal angles
    localparam int INT_ANG_BITS = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_FOV_MODE      = 2'd0;
    localparam logic [1:0] CFG_FOV_SETTING   = 2'd1;
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd3;

    typedef struct packed {
        logic        fov_mode;
        logic [15:0] fov_setting;
        logic [13:0] screen_width;
        logic [13:0] screen_height;
    } cfg_t;

    // atan(2^-k) in 2^-16 degree, rounded to nearest
    function automatic logic signed [ZW-1:0] atan_val(input int k);
        logic signed [ZW-1:0] v;
        case (k)
            0:  v = 26'sd2949120;
            1:  v = 26'sd1740967;
            2:  v = 26'sd919879;
            3:  v = 26'sd466945;
            4:  v = 26'sd234379;
            5:  v = 26'sd117304;
            6:  v = 26'sd58666;
            7:  v = 26'sd29335;
            8:  v = 26'sd14668;
            9:  v = 26'sd7334;
            10: v = 26'sd3667;
            11: v = 26'sd1833;
            12: v = 26'sd917;
            13: v = 26'sd458;
            14: v = 26'sd229;
            15: v = 26'sd115;
            16: v = 26'sd57;
            17: v = 26'sd29;
            18: v = 26'sd14;
            19: v = 26'sd7;
            20: v = 26'sd4;
            21: v = 26'sd2;
            22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/pova_if.sv =====
interface pova_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] offset_x;
    logic signed [14:0] offset_y;

    modport source (output valid, output offset_x, output offset_y, input ready);
    modport sink (input valid, input offset_x, input offset_y, output ready);
endinterface

interface pova_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;

    modport source (output valid, output yaw_angle, output pitch_angle, input ready);
    modport sink (input valid, input yaw_angle, input pitch_angle, output ready);
endinterface

// ===== rtl/pixel_offset_to_view_angles.sv =====
// Pixel offset to yaw and pitch under a pinhole camera. Takes one offset word
// per clock and returns one angle word per clock while the sink takes each word;
// the path runs through the rotation CORDIC pipeline (tangent of half
// the FOV), two multiply stages and the two vectoring CORDIC lanes (one for
// yaw, one for pitch) that run side by side. When the output word is held by
// the sink the whole pipeline holds. Angles are in 1/2^ANGLE_FRAC_BITS degree
// and saturate at +-90 degrees. Write configuration only while idle.
module pixel_offset_to_view_angles
    import pova_pkg::*;
#(
    parameter int MAX_DIM         = 8192,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_ITERS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    pova_in_if.sink     in_ch,
    pova_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data
);

    localparam int ASH  = INT_ANG_BITS - ANGLE_FRAC_BITS;
    localparam int L    = 2 * CORDIC_ITERS + 3;
    localparam logic signed [27:0] LIM = 28'sd90 <<< ANGLE_FRAC_BITS;
    localparam logic signed [27:0] HALF = 28'sd1 <<< ASH;

    cfg_t                 cfg_reg;
    logic [L-1:0]         vld_reg;
    logic                 out_vld_reg;
    logic signed [15:0]   yaw_reg;
    logic signed [15:0]   pitch_reg;
    logic                 advance;
    logic signed [VW-1:0] den;
    logic signed [VW-1:0] num_x;
    logic signed [VW-1:0] num_y;
    logic signed [ZW-1:0] z_yaw;
    logic signed [ZW-1:0] z_pitch;

    function automatic logic signed [15:0] to_out(input logic signed [ZW-1:0] z);
        logic signed [27:0] r;
        r = ((28'(z) <<< 1) + HALF) >>> (ASH + 1);
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[15:0];
    endfunction

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fov_mode      <= 1'b0;
            cfg_reg.fov_setting   <= 16'd23040;
            cfg_reg.screen_width  <= 14'd1920;
            cfg_reg.screen_height <= 14'd1080;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_FOV_MODE:      cfg_reg.fov_mode      <= cfg_data[0];
                CFG_FOV_SETTING:   cfg_reg.fov_setting   <= cfg_data;
                CFG_SCREEN_WIDTH:  cfg_reg.screen_width  <= cfg_data[13:0];
                CFG_SCREEN_HEIGHT: cfg_reg.screen_height <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // pipeline moves unless the output word is stuck
    assign advance     = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = advance;

    pova_tan #(
        .MAX_DIM         (MAX_DIM),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .CORDIC_ITERS    (CORDIC_ITERS)
    ) u_tan (
        .clk      (clk),
        .en       (advance),
        .cfg      (cfg_reg),
        .offset_x (in_ch.offset_x),
        .offset_y (in_ch.offset_y),
        .den      (den),
        .num_x    (num_x),
        .num_y    (num_y)
    );

    pova_lane #(.CORDIC_ITERS(CORDIC_ITERS)) u_lane_yaw (
        .clk   (clk),
        .en    (advance),
        .den   (den),
        .num   (num_x),
        .angle (z_yaw)
    );

    pova_lane #(.CORDIC_ITERS(CORDIC_ITERS)) u_lane_pitch (
        .clk   (clk),
        .en    (advance),
        .den   (den),
        .num   (num_y),
        .angle (z_pitch)
    );

    // valid tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= {vld_reg[L-2:0], in_ch.valid};
            out_vld_reg <= vld_reg[L-1];
        end
    end

    // merge lanes into the output word
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            yaw_reg   <= to_out(z_yaw);
            pitch_reg <= to_out(z_pitch);
        end
    end

    assign out_ch.valid       = out_vld_reg;
    assign out_ch.yaw_angle   = yaw_reg;
    assign out_ch.pitch_angle = pitch_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_when_stuck: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ch.ready) |-> !in_ch.ready)
        else $error("input accepted while pipeline held");
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> vld_reg[0])
        else $error("accepted word missing from first stage");
    a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_ch.ready) |=> $stable(vld_reg))
        else $error("pipeline moved while held");
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(vld_reg[L-1]))
        else $error("output word without a source");
`endif

endmodule

// ===== rtl/pova_tan.sv =====
module pova_tan
    import pova_pkg::*;
#(
    parameter int MAX_DIM         = 8192,
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int CORDIC_ITERS    = 16
)
(
    input  logic                  clk,
    input  logic                  en,
    input  cfg_t                  cfg,
    input  logic signed [14:0]    offset_x,
    input  logic signed [14:0]    offset_y,
    output logic signed [VW-1:0]  den,
    output logic signed [VW-1:0]  num_x,
    output logic signed [VW-1:0]  num_y
);

    localparam int ASH = INT_ANG_BITS - ANGLE_FRAC_BITS;
    localparam logic [23:0] FOV_MAX = 24'(179 << ANGLE_FRAC_BITS);
    localparam logic [16:0] DIM_MAX = 17'(MAX_DIM);

    logic        [23:0]   fov_c;
    logic signed [ZW-1:0] z0_next;

    logic signed [RW-1:0] cx_reg [0:CORDIC_ITERS];
    logic signed [RW-1:0] sy_reg [0:CORDIC_ITERS];
    logic signed [ZW-1:0] z_reg  [0:CORDIC_ITERS];
    logic signed [14:0]   ox_reg [0:CORDIC_ITERS+1];
    logic signed [14:0]   oy_reg [0:CORDIC_ITERS+1];

    logic        [13:0]   w_c;
    logic        [13:0]   h_c;
    logic        [14:0]   dim;
    logic signed [RW-1:0] cx_pos;
    logic signed [49:0]   den_prod;
    logic signed [NW-1:0] ns_next;
    logic signed [VW-1:0] den_reg;
    logic signed [VW-1:0] den2_reg;
    logic signed [NW-1:0] ns_reg;
    logic signed [50:0]   px;
    logic signed [50:0]   py;
    logic signed [VW-1:0] nx_reg;
    logic signed [VW-1:0] ny_reg;

    // half fov start angle
    always_comb
    begin
        fov_c   = ({8'b0, cfg.fov_setting} > FOV_MAX) ? FOV_MAX : {8'b0, cfg.fov_setting};
        z0_next = ZW'(({2'b0, fov_c} << ASH) >> 1);
    end

    // input stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= RW'(64'sd1 << 30);
            sy_reg[0] <= '0;
            z_reg[0]  <= z0_next;
            ox_reg[0] <= offset_x;
            oy_reg[0] <= offset_y;
        end
    end

    // rotation stages, one micro-rotation each
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_rot
        logic signed [RW-1:0] dx;
        logic signed [RW-1:0] dy;
        assign dx = sy_reg[i] >>> i;
        assign dy = cx_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] - dx;
                    sy_reg[i+1] <= sy_reg[i] + dy;
                    z_reg[i+1]  <= z_reg[i] - atan_val(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + dx;
                    sy_reg[i+1] <= sy_reg[i] - dy;
                    z_reg[i+1]  <= z_reg[i] + atan_val(i);
                end
                ox_reg[i+1] <= ox_reg[i];
                oy_reg[i+1] <= oy_reg[i];
            end
        end
    end

    // denominator and numerator scale
    always_comb
    begin
        w_c = ({3'b0, cfg.screen_width} > DIM_MAX) ? DIM_MAX[13:0] : cfg.screen_width;
        h_c = ({3'b0, cfg.screen_height} > DIM_MAX) ? DIM_MAX[13:0] : cfg.screen_height;
        dim = cfg.fov_mode ? {h_c, 1'b0} : {1'b0, w_c};
        cx_pos = (cx_reg[CORDIC_ITERS] <= 0) ? RW'(1) : cx_reg[CORDIC_ITERS];
        den_prod = $signed({1'b0, dim}) * cx_pos;
        if (cfg.fov_mode)
            ns_next = (NW'(sy_reg[CORDIC_ITERS]) <<< 1) + NW'(sy_reg[CORDIC_ITERS]);
        else
            ns_next = NW'(sy_reg[CORDIC_ITERS]) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg <= VW'(den_prod);
            ns_reg  <= ns_next;
            ox_reg[CORDIC_ITERS+1] <= ox_reg[CORDIC_ITERS];
            oy_reg[CORDIC_ITERS+1] <= oy_reg[CORDIC_ITERS];
        end
    end

    // offset times scaled tangent
    assign px = ox_reg[CORDIC_ITERS+1] * ns_reg;
    assign py = oy_reg[CORDIC_ITERS+1] * ns_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den2_reg <= den_reg;
            nx_reg   <= VW'(px);
            ny_reg   <= VW'(py);
        end
    end

    assign den   = den2_reg;
    assign num_x = nx_reg;
    assign num_y = ny_reg;

endmodule

// ===== rtl/pova_lane.sv =====
module pova_lane
    import pova_pkg::*;
#(
    parameter int CORDIC_ITERS = 16
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [VW-1:0]  den,
    input  logic signed [VW-1:0]  num,
    output logic signed [ZW-1:0]  angle
);

    logic signed [VW-1:0] x_reg [0:CORDIC_ITERS-1];
    logic signed [VW-1:0] y_reg [0:CORDIC_ITERS-1];
    logic signed [ZW-1:0] z_reg [0:CORDIC_ITERS-1];

    // vectoring stages, drive y toward zero
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_vec
        logic signed [VW-1:0] xs;
        logic signed [VW-1:0] ys;
        logic signed [ZW-1:0] zs;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        if (i == 0)
        begin : g_first
            assign xs = den;
            assign ys = num;
            assign zs = '0;
        end
        else
        begin : g_next
            assign xs = x_reg[i-1];
            assign ys = y_reg[i-1];
            assign zs = z_reg[i-1];
        end
        assign dx = ys >>> i;
        assign dy = xs >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (ys >= 0)
                begin
                    x_reg[i] <= xs + dx;
                    y_reg[i] <= ys - dy;
                    z_reg[i] <= zs + atan_val(i);
                end
                else
                begin
                    x_reg[i] <= xs - dx;
                    y_reg[i] <= ys + dy;
                    z_reg[i] <= zs - atan_val(i);
                end
            end
        end
    end

    assign angle = z_reg[CORDIC_ITERS-1];

endmodule

// ===== dv/tb_pixel_offset_to_view_angles.sv =====
module tb_pixel_offset_to_view_angles
    import pova_pkg::*;
();

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
    } angles_t;

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;

    pova_in_if  in_ch ();
    pova_out_if out_ch ();

    pixel_offset_to_view_angles DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch.sink),
        .out_ch   (out_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // local copy of the configuration
    logic        mdl_mode;
    logic [15:0] mdl_fov;
    logic [13:0] mdl_w;
    logic [13:0] mdl_h;

    angles_t expected_angles[$];
    int      mismatch_count;
    int      burst_left;
    bit      stall_enable;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50000000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint table_atan(input int k);
        longint t[23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                          57, 29, 14, 7, 4, 2, 1};
        return (k < 23) ? t[k] : 0;
    endfunction

    // vectoring rotation toward the x axis, accumulating the angle
    function automatic longint atan_of(input longint den, input longint num);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = den;
        y = num;
        z = 0;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx; y -= dy; z += table_atan(i);
            end
            else
            begin
                x -= dx; y += dy; z -= table_atan(i);
            end
        end
        return z;
    endfunction

    function automatic logic signed [15:0] round_sat(input longint z);
        longint r;
        r = (2 * z + (64'sd1 <<< 8)) >>> 9;
        if (r > 23040) r = 23040;
        if (r < -23040) r = -23040;
        return r[15:0];
    endfunction

    function automatic angles_t view_angles(input logic signed [14:0] ox,
                                            input logic signed [14:0] oy);
        longint fov;
        longint w;
        longint h;
        longint cx;
        longint sy;
        longint z;
        longint dx;
        longint dy;
        longint dscale;
        longint nscale;
        angles_t a;
        fov = (mdl_fov > 179 * 256) ? 179 * 256 : mdl_fov;
        w = (mdl_w > 8192) ? 8192 : mdl_w;
        h = (mdl_h > 8192) ? 8192 : mdl_h;
        cx = 64'sd1 <<< 30;
        sy = 0;
        z = (fov <<< 8) >>> 1;
        // rotation for sine and cosine of half the fov
        for (int i = 0; i < 16; i++)
        begin
            dx = sy >>> i;
            dy = cx >>> i;
            if (z >= 0)
            begin
                cx -= dx; sy += dy; z -= table_atan(i);
            end
            else
            begin
                cx += dx; sy -= dy; z += table_atan(i);
            end
        end
        if (cx <= 0) cx = 1;
        if (mdl_mode)
        begin
            dscale = 2 * h * cx; nscale = 3 * sy;
        end
        else
        begin
            dscale = w * cx; nscale = 2 * sy;
        end
        a.yaw   = round_sat(atan_of(dscale, longint'(ox) * nscale));
        a.pitch = round_sat(atan_of(dscale, longint'(oy) * nscale));
        return a;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // receiver stall pattern and result check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_angles.size() == 0)
                begin
                    report_mismatch("unexpected word", out_ch.yaw_angle, 0);
                end
                else
                begin
                    angles_t e;
                    e = expected_angles.pop_front();
                    if (out_ch.yaw_angle !== e.yaw)
                        report_mismatch("yaw", out_ch.yaw_angle, e.yaw);
                    if (out_ch.pitch_angle !== e.pitch)
                        report_mismatch("pitch", out_ch.pitch_angle, e.pitch);
                end
            end
            out_ch.ready <= stall_enable ? (($urandom_range(0, 7) < 5)
                                            || (($time / 640) % 3 == 0)) : 1'b1;
        end
    end

    // one register write; the caller drops the write enable
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_FOV_MODE:      mdl_mode = val[0];
            CFG_FOV_SETTING:   mdl_fov = val;
            CFG_SCREEN_WIDTH:  mdl_w = val[13:0];
            CFG_SCREEN_HEIGHT: mdl_h = val[13:0];
            default: ;
        endcase
    endtask

    task automatic set_view(input logic m, input logic [15:0] f,
                            input logic [13:0] w, input logic [13:0] h);
        write_reg(CFG_FOV_MODE, {15'd0, m});
        write_reg(CFG_FOV_SETTING, f);
        write_reg(CFG_SCREEN_WIDTH, {2'd0, w});
        write_reg(CFG_SCREEN_HEIGHT, {2'd0, h});
        cfg_we <= 1'b0;
    endtask

    // send one offset word, with bursts and random gaps
    task automatic send_offset(input logic signed [14:0] ox, input logic signed [14:0] oy);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_ch.valid    <= 1'b1;
        in_ch.offset_x <= ox;
        in_ch.offset_y <= oy;
        expected_angles.push_back(view_angles(ox, oy));
        do @(posedge clk); while (!in_ch.ready);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        while (expected_angles.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic signed [14:0] rand_offset;
        case ($urandom_range(0, 3))
            0: return 15'($urandom_range(0, 16383) - 8192);
            1: return 15'($urandom_range(0, 64) - 32);
            2: return 15'($urandom);
            default: return $urandom_range(0, 1) ? 15'sd8192 : -15'sd8192;
        endcase
    endfunction

    task automatic test_directed;
        logic signed [14:0] edges[8] = '{15'sd0, 15'sd1, -15'sd1, 15'sd8192, -15'sd8192,
                                         15'sd16383, 15'sh4000, 15'sd100};
        foreach (edges[i])
            send_offset(edges[i], edges[7 - i]);
        drain();
    endtask

    task automatic test_fov_modes;
        // extremes of the registers, including zero sizes and wide fov
        set_view(1'b1, 16'd23040, 14'd1920, 14'd1080);
        for (int i = 0; i < 6; i++) send_offset(rand_offset(), rand_offset());
        drain();
        set_view(1'b0, 16'hFFFF, 14'h3FFF, 14'd0);
        for (int i = 0; i < 4; i++) send_offset(rand_offset(), rand_offset());
        drain();
        set_view(1'b1, 16'd0, 14'd0, 14'h3FFF);
        send_offset(15'sd5, -15'sd5);
        send_offset(15'sd0, 15'sd0);
        drain();
        set_view(1'b0, 16'd256, 14'd1, 14'd1);
        send_offset(15'sd8192, -15'sd8192);
        send_offset(15'sd1, 15'sd0);
        drain();
    endtask

    task automatic test_random;
        for (int p = 0; p < 10; p++)
        begin
            stall_enable = (p % 3 != 2);
            set_view(1'($urandom_range(0, 1)),
                     16'((p % 4 == 0) ? $urandom : $urandom_range(256, 45824)),
                     14'((p % 5 == 0) ? $urandom : $urandom_range(1, 8192)),
                     14'((p % 5 == 1) ? $urandom : $urandom_range(1, 8192)));
            for (int i = 0; i < 100; i++)
                send_offset(rand_offset(), rand_offset());
            drain();
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_FOV_MODE;
        cfg_data = 16'd0;
        in_ch.valid = 1'b0;
        in_ch.offset_x = '0;
        in_ch.offset_y = '0;
        mismatch_count = 0;
        burst_left = 0;
        stall_enable = 1'b1;
        mdl_mode = 1'b0;
        mdl_fov = 16'd23040;
        mdl_w = 14'd1920;
        mdl_h = 14'd1080;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fov_modes();
        test_random();
        if (mismatch_count == 0 && expected_angles.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
